// ===== src/dsdv_pkg.sv =====
// Shared types and constants for the DSDV route table update block.
// No dependencies; the front end, back end and top level import this package.
package dsdv_pkg;

  // Table geometry
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned HopW     = 8;
  localparam logic [HopW-1:0] HopMax = {HopW{1'b1}};
  localparam int unsigned SeqW     = 32;
  localparam logic [SeqW-1:0] SeqMax     = {SeqW{1'b1}};
  localparam logic [SeqW-1:0] SeqBumpLim = SeqMax - SeqW'(1);
  localparam logic [SeqW-1:0] SeqBump    = SeqW'(2);

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Request kinds
  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_MERGE  = 2'd1,
    REQ_BUMP   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  // Input item
  typedef struct packed {
    logic [1:0]      req_type;
    logic [5:0]      destination;
    logic [7:0]      advertised_hops;
    logic [31:0]     advertised_seq;
    logic [5:0]      neighbor;
  } req_t;

  // Result item
  typedef struct packed {
    logic            found;
    logic [5:0]      next_hop;
    logic [7:0]      hop_count;
    logic [31:0]     seq_number;
    logic            changed;
  } rsp_t;

  // Classified command handed from front to back
  typedef struct packed {
    req_e              kind;
    logic [NodeW-1:0]  idx;
    logic [7:0]        adv_hops;
    logic [SeqW-1:0]   adv_seq;
    logic [NodeW-1:0]  neighbor;
  } cmd_t;

  // One stored route
  typedef struct packed {
    logic [NodeW-1:0]  next_hop;
    logic [HopW-1:0]   hops;
    logic [SeqW-1:0]   seq;
  } entry_t;

endpackage

// ===== src/dsdv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsdv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dsdv_front.sv =====
// Front end: accepts request items, resolves the table index and queues them.
// Depends on dsdv_pkg.
module dsdv_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dsdv_pkg::NodeW-1:0] own_node_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dsdv_pkg::req_t            in_data_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_pop_i,
  output dsdv_pkg::cmd_t            cmd_o
);
  import dsdv_pkg::*;

  cmd_t             queue_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] count_q, count_d;
  cmd_t             cmd_new;
  logic             push;

  // Classify: init and bump address the own entry, the rest the destination
  always_comb begin
    cmd_new.kind     = req_e'(in_data_i.req_type);
    cmd_new.adv_hops = in_data_i.advertised_hops;
    cmd_new.adv_seq  = in_data_i.advertised_seq;
    cmd_new.neighbor = in_data_i.neighbor;
    if (in_data_i.req_type inside {REQ_INIT, REQ_BUMP}) begin
      cmd_new.idx = own_node_i;
    end else begin
      cmd_new.idx = in_data_i.destination;
    end
  end

  assign in_ready_o  = (count_q != QCntW'(QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rptr_q];

  // Advance pointers and fill count
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (cmd_pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ===== src/dsdv_back.sv =====
// Back end: read-modify-write of the route table and the result register.
// Depends on dsdv_pkg and dsdv_ram.
module dsdv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  dsdv_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dsdv_pkg::rsp_t out_data_o
);
  import dsdv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cur_q;
  logic [MaxNodes-1:0] valid_q;
  logic                out_valid_q;
  rsp_t                out_q;
  entry_t              rd_entry;
  entry_t              wr_entry;
  entry_t              res_entry;
  logic                we;
  logic                vld;
  logic                found;
  logic [HopW:0]       hop_sum;
  logic [HopW-1:0]     new_hops;
  rsp_t                rsp;

  // Route storage
  dsdv_ram #(
    .Width($bits(entry_t)),
    .Depth(MaxNodes)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cur_q.idx),
    .wdata_i(wr_entry),
    .re_i   (cmd_pop_o),
    .raddr_i(cmd_i.idx),
    .rdata_o(rd_entry)
  );

  // Start an item only when the result slot is free at the next edge
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && (!out_valid_q || out_ready_i);

  assign vld      = valid_q[cur_q.idx];
  assign hop_sum  = {1'b0, cur_q.adv_hops} + (HopW + 1)'(1);
  assign new_hops = (hop_sum > {1'b0, HopMax}) ? HopMax : hop_sum[HopW-1:0];

  // Decide the table update
  always_comb begin
    we       = 1'b0;
    wr_entry = rd_entry;
    if (state_q == S_EXEC) begin
      case (cur_q.kind)
        REQ_INIT: begin
          we       = 1'b1;
          wr_entry = '{next_hop: cur_q.idx, hops: '0, seq: '0};
        end
        REQ_MERGE: begin
          if (!vld || (cur_q.adv_seq > rd_entry.seq) ||
              ((cur_q.adv_seq == rd_entry.seq) && (new_hops < rd_entry.hops))) begin
            we       = 1'b1;
            wr_entry = '{next_hop: cur_q.neighbor, hops: new_hops, seq: cur_q.adv_seq};
          end
        end
        REQ_BUMP: begin
          if (vld) begin
            we           = 1'b1;
            wr_entry.seq = (rd_entry.seq >= SeqBumpLim) ? SeqMax : rd_entry.seq + SeqBump;
          end
        end
        REQ_LOOKUP: begin
          we = 1'b0;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // Build the result from the entry as it stands after the item
  always_comb begin
    found     = we || vld;
    res_entry = we ? wr_entry : rd_entry;
    rsp       = '0;
    if (found) begin
      rsp.found      = 1'b1;
      rsp.next_hop   = res_entry.next_hop;
      rsp.hop_count  = res_entry.hops[7:0];
      rsp.seq_number = res_entry.seq;
      rsp.changed    = we;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) begin
        valid_q[cur_q.idx] <= 1'b1;
      end
      if (state_q == S_EXEC) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the command and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (state_q == S_EXEC) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/dsdv_route_table_update.sv =====
// DSDV route table update block, top level.
// Depends on dsdv_pkg, dsdv_front, dsdv_back and dsdv_ram.
//
// Usage:
//   Configuration: write own_node on cfg_valid_i/cfg_ready_o with the data on
//   cfg_own_node_i; the port is always ready. Write only while no item is in
//   flight.
//   Requests: in_valid_i/in_ready_o carry one item (init, merge, bump or
//   lookup). Each item gives exactly one result on out_valid_o/out_ready_i,
//   describing the addressed entry after the item.
//   Latency: when the output is free, a transferred item passes the queue,
//   then the command register and the registered table read, then the result register.
//   Pacing: the engine takes a new item only after the last one has finished the
//   read-modify-write of the route table RAM (registered read, then compare and write back).
//   A 2-entry queue sits between the front end and the table engine, so
//   items keep being transferred while a result waits at the output.
//   Reset: all route valid bits, the queue and own_node clear at once; the
//   table RAM contents are only read behind a set valid bit.
//   Stall: when out_ready_i is low the result register holds, the engine
//   stops, the queue fills and then in_ready_o drops.
module dsdv_route_table_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dsdv_pkg::NodeW-1:0] cfg_own_node_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  dsdv_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output dsdv_pkg::rsp_t             out_data_o
);
  import dsdv_pkg::*;

  logic [NodeW-1:0] own_node_q;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_q <= '0;
    end else if (cfg_valid_i) begin
      own_node_q <= cfg_own_node_i;
    end
  end

  dsdv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .own_node_i (own_node_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  dsdv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // A written entry is always reported as present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.changed |-> out_data_o.found)
    else $error("changed result without found");

  // A missing entry reports zero route fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      (out_data_o.next_hop == '0) && (out_data_o.hop_count == '0) &&
      (out_data_o.seq_number == '0) && !out_data_o.changed)
    else $error("missing entry with nonzero fields");

  // The table engine takes one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !cmd_pop)
    else $error("engine popped two commands back to back");

  // Only a queued command can be started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("pop from an empty queue");

endmodule
